// File: hdl/assert_macros.svh
// Assertion macros used by the checker module of the PLL factor solver.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PFS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PFS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/pfs_pkg.sv
// Constants, tables and helper functions of the PLL factor solver.
package pfs_pkg;

  localparam int unsigned NUM_DIV   = 8;
  localparam int unsigned IDX_W     = $clog2(NUM_DIV);
  localparam int unsigned TGT_W     = 12;
  localparam int unsigned MUL_W     = 8;
  localparam int unsigned DIV_W     = 5;
  localparam int unsigned FULL_W    = 12;  // multiplier before range check
  localparam int unsigned MUL_DIRECT_MAX = 32;
  localparam int unsigned MUL_MAX   = 128;
  localparam logic [31:0] PLL_ENABLE = 32'h8000_0000;

  // Reciprocal of 24 for a 12-bit target: floor(t * 2731 / 2^16) == t / 24.
  localparam logic [11:0] RECIP24_T = 12'd2731;
  // Reciprocal of 24 for products up to 368: floor(x * 171 / 2^12) == x / 24.
  localparam logic [7:0]  RECIP24_S = 8'd171;
  // Reciprocal of 3 for values up to 128: floor(x * 171 / 2^9) == x / 3.
  localparam logic [7:0]  RECIP3    = 8'd171;

  // Candidate total dividers, tried lowest index first.
  localparam logic [DIV_W-1:0] DIV_LIST [NUM_DIV] =
    '{5'd1, 5'd2, 5'd3, 5'd4, 5'd6, 5'd8, 5'd12, 5'd16};
  // Pre-divider code (m - 1) and post-divider code for each divider.
  localparam logic [1:0] M_CODE [NUM_DIV] =
    '{2'd0, 2'd0, 2'd2, 2'd0, 2'd2, 2'd1, 2'd2, 2'd3};
  localparam logic [1:0] P_CODE [NUM_DIV] =
    '{2'd0, 2'd1, 2'd0, 2'd2, 2'd1, 2'd2, 2'd2, 2'd2};

  typedef struct packed {
    logic       ok;   // r * d is a multiple of 24
    logic [3:0] quo;  // r * d / 24
  } frac_t;

  // Residue r (0..23) times divider d, divided by 24 when exact.
  function automatic frac_t frac_div24(logic [4:0] r, logic [DIV_W-1:0] d);
    logic [8:0]  prod;
    logic [15:0] wide;
    logic [3:0]  quo;
    frac_t       res;
    prod    = 9'({4'd0, r} * {4'd0, d});
    wide    = 16'({7'd0, prod} * {8'd0, RECIP24_S});
    quo     = wide[15:12];
    res.ok  = (prod == 9'({5'd0, quo} * 9'd24));
    res.quo = quo;
    return res;
  endfunction

  // True when an 8-bit value is a multiple of three (digit sum in base four).
  function automatic logic mod3_zero(logic [7:0] v);
    logic [3:0] s;
    logic [2:0] s2;
    logic [2:0] s3;
    s  = {2'd0, v[7:6]} + {2'd0, v[5:4]} + {2'd0, v[3:2]} + {2'd0, v[1:0]};
    s2 = {1'b0, s[3:2]} + {1'b0, s[1:0]};
    s3 = {1'b0, s2[1:0]} + {2'd0, s2[2]};
    return (s3 == 3'd0) || (s3 == 3'd3);
  endfunction

endpackage

// File: hdl/pll_factor_solver.sv
// Top level of the PLL factor solver: a five-stage pipeline from target to PLL word.
//
// Usage: a request carries one target frequency (target_mhz_i, whole MHz) against
// the fixed 24 MHz reference. Each request yields exactly one result on the
// output channel: the chosen multiplier and divider, the n, k, m and p codes,
// the frequency reached and the packed PLL word with its enable bit set. When
// no factor set fits, found_o is low and every other result field is zero.
// Both channels use valid/ready; a request moves when valid and ready are high.
// Throughput is one request per cycle unless a valid result is stalled: the
// five stages (reciprocal multiply, residue, per-divider multipliers, range
// check with priority pick, n/k split and packing) each hold an item and
// advance together. When the receiver stalls a valid result, the whole
// pipeline holds and in_ready_o drops; nothing is lost or repeated, and
// ready returns as soon as the output is taken. Bubbles inside a stalled
// pipeline stay in place, but with no result waiting the pipeline moves
// even if the receiver is not ready. Reset clears every stage valid bit;
// the block is ready right after reset.
module pll_factor_solver (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [11:0] target_mhz_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        found_o,
  output logic [7:0]  multiplier_o,
  output logic [4:0]  divider_o,
  output logic [4:0]  n_code_o,
  output logic [1:0]  k_code_o,
  output logic [1:0]  m_code_o,
  output logic [1:0]  p_code_o,
  output logic [11:0] achieved_mhz_o,
  output logic [31:0] pll_word_o
);

  localparam int unsigned ND = pfs_pkg::NUM_DIV;

  // The pipeline advances whenever the output register is empty or being taken.
  logic adv;

  // Stage valid bits.
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q, out_v_q;

  // Stage 1: target and its quotient by 24.
  logic [11:0] s1_t_q;
  logic [7:0]  s1_q_q;
  logic [23:0] s1_prod;

  // Stage 2: target, quotient and residue.
  logic [11:0] s2_t_q;
  logic [7:0]  s2_q_q;
  logic [4:0]  s2_r_q;
  logic [11:0] s2_r_d;

  // Stage 3: multiplier and divisibility for every candidate divider.
  logic [11:0] s3_t_q;
  logic [pfs_pkg::FULL_W-1:0] s3_mul_q [ND];
  logic [ND-1:0]              s3_ok_q;
  logic [pfs_pkg::FULL_W-1:0] s3_mul_d [ND];
  logic [ND-1:0]              s3_ok_d;

  // Stage 4: first acceptable divider.
  logic [11:0]               s4_t_q;
  logic                      s4_hit_q;
  logic [pfs_pkg::MUL_W-1:0] s4_mul_q;
  logic [pfs_pkg::IDX_W-1:0] s4_idx_q;
  logic                      s4_hit_d;
  logic [pfs_pkg::MUL_W-1:0] s4_mul_d;
  logic [pfs_pkg::IDX_W-1:0] s4_idx_d;
  logic [ND-1:0]             s4_lane_ok;

  // Output stage.
  logic        found_q, found_d;
  logic [7:0]  mult_q, mult_d;
  logic [4:0]  div_q, div_d;
  logic [4:0]  ncode_q, ncode_d;
  logic [1:0]  kcode_q, kcode_d;
  logic [1:0]  mcode_q, mcode_d;
  logic [1:0]  pcode_q, pcode_d;
  logic [11:0] ach_q, ach_d;
  logic [31:0] word_q, word_d;

  logic [15:0] s5_prod3;
  logic [7:0]  s5_n;
  logic [1:0]  s5_k;
  logic        s5_split;

  assign adv        = !out_v_q || out_ready_i;
  assign in_ready_o = adv;

  // Stage 1: quotient by 24 through a reciprocal multiply.
  assign s1_prod = 24'({12'd0, target_mhz_i} * {12'd0, pfs_pkg::RECIP24_T});

  // Stage 2: residue = t - 24q, with 24q built from shifts.
  assign s2_r_d = s1_t_q - ({s1_q_q, 4'd0} + {1'b0, s1_q_q, 3'd0});

  // Stage 3: M = q*D + r*D/24, valid only when r*D is a multiple of 24.
  always_comb begin
    pfs_pkg::frac_t fr;
    fr = '0;
    for (int i = 0; i < ND; i++) begin
      fr          = pfs_pkg::frac_div24(s2_r_q, pfs_pkg::DIV_LIST[i]);
      s3_mul_d[i] = 12'({4'd0, s2_q_q} * {7'd0, pfs_pkg::DIV_LIST[i]})
                    + {8'd0, fr.quo};
      s3_ok_d[i]  = fr.ok;
    end
  end

  // Stage 4: range check per lane, then the lowest acceptable lane wins.
  always_comb begin
    for (int i = 0; i < ND; i++) begin
      s4_lane_ok[i] = s3_ok_q[i]
                      && (s3_mul_q[i] <= 12'(pfs_pkg::MUL_MAX))
                      && ((s3_mul_q[i] <= 12'(pfs_pkg::MUL_DIRECT_MAX))
                          || !s3_mul_q[i][0]
                          || pfs_pkg::mod3_zero(s3_mul_q[i][7:0]));
    end
    s4_hit_d = 1'b0;
    s4_mul_d = '0;
    s4_idx_d = '0;
    for (int i = ND - 1; i >= 0; i--) begin
      if (s4_lane_ok[i]) begin
        s4_hit_d = 1'b1;
        s4_mul_d = s3_mul_q[i][pfs_pkg::MUL_W-1:0];
        s4_idx_d = pfs_pkg::IDX_W'(i);
      end
    end
  end

  // Stage 5: split M into n*k with the smallest k, then pack the result.
  // The frequency reached equals the target whenever a set is found, since
  // 24*M/D undoes the exact division that produced M.
  assign s5_prod3 = 16'({8'd0, s4_mul_q} * {8'd0, pfs_pkg::RECIP3});

  always_comb begin
    s5_split = 1'b1;
    s5_n     = s4_mul_q;
    s5_k     = 2'd0;
    if (s4_mul_q <= 8'(pfs_pkg::MUL_DIRECT_MAX)) begin
      s5_n = s4_mul_q;
      s5_k = 2'd0;
    end else if (!s4_mul_q[0] && (s4_mul_q <= 8'(2 * pfs_pkg::MUL_DIRECT_MAX))) begin
      s5_n = {1'b0, s4_mul_q[7:1]};
      s5_k = 2'd1;
    end else if (pfs_pkg::mod3_zero(s4_mul_q)
                 && (s4_mul_q <= 8'(3 * pfs_pkg::MUL_DIRECT_MAX))) begin
      s5_n = {1'b0, s5_prod3[15:9]};
      s5_k = 2'd2;
    end else if (s4_mul_q[1:0] == 2'd0) begin
      s5_n = {2'd0, s4_mul_q[7:2]};
      s5_k = 2'd3;
    end else begin
      s5_split = 1'b0;
    end

    found_d = s4_hit_q && (s4_mul_q != 8'd0) && s5_split;
    mult_d  = '0;
    div_d   = '0;
    ncode_d = '0;
    kcode_d = '0;
    mcode_d = '0;
    pcode_d = '0;
    ach_d   = '0;
    word_d  = '0;
    if (found_d) begin
      mult_d  = s4_mul_q;
      div_d   = pfs_pkg::DIV_LIST[s4_idx_q];
      ncode_d = 5'(s5_n - 8'd1);
      kcode_d = s5_k;
      mcode_d = pfs_pkg::M_CODE[s4_idx_q];
      pcode_d = pfs_pkg::P_CODE[s4_idx_q];
      ach_d   = s4_t_q;
      word_d  = pfs_pkg::PLL_ENABLE
                | {14'd0, pcode_d, 16'd0}
                | {19'd0, ncode_d, 8'd0}
                | {26'd0, kcode_d, 4'd0}
                | {30'd0, mcode_d};
    end
  end

  // Valid bits travel with the data and hold while the pipeline is stalled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q  <= in_valid_i;
      s2_v_q  <= s1_v_q;
      s3_v_q  <= s2_v_q;
      s4_v_q  <= s3_v_q;
      out_v_q <= s4_v_q;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_t_q   <= target_mhz_i;
      s1_q_q   <= s1_prod[23:16];
      s2_t_q   <= s1_t_q;
      s2_q_q   <= s1_q_q;
      s2_r_q   <= s2_r_d[4:0];
      s3_t_q   <= s2_t_q;
      s3_mul_q <= s3_mul_d;
      s3_ok_q  <= s3_ok_d;
      s4_t_q   <= s3_t_q;
      s4_hit_q <= s4_hit_d;
      s4_mul_q <= s4_mul_d;
      s4_idx_q <= s4_idx_d;
      found_q  <= found_d;
      mult_q   <= mult_d;
      div_q    <= div_d;
      ncode_q  <= ncode_d;
      kcode_q  <= kcode_d;
      mcode_q  <= mcode_d;
      pcode_q  <= pcode_d;
      ach_q    <= ach_d;
      word_q   <= word_d;
    end
  end

  assign out_valid_o    = out_v_q;
  assign found_o        = found_q;
  assign multiplier_o   = mult_q;
  assign divider_o      = div_q;
  assign n_code_o       = ncode_q;
  assign k_code_o       = kcode_q;
  assign m_code_o       = mcode_q;
  assign p_code_o       = pcode_q;
  assign achieved_mhz_o = ach_q;
  assign pll_word_o     = word_q;

endmodule

// File: hdl/pfs_checker.sv
// Port-level checker of the PLL factor solver and its bind statement.
`include "assert_macros.svh"

module pfs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        found_i,
  input logic [7:0]  multiplier_i,
  input logic [4:0]  divider_i,
  input logic [4:0]  n_code_i,
  input logic [1:0]  k_code_i,
  input logic [1:0]  m_code_i,
  input logic [1:0]  p_code_i,
  input logic [11:0] achieved_mhz_i,
  input logic [31:0] pll_word_i
);

  logic        miss_zero;
  logic        word_match;
  logic        factor_match;

  assign miss_zero = (multiplier_i == 8'd0) && (divider_i == 5'd0)
                     && (achieved_mhz_i == 12'd0) && (pll_word_i == 32'd0);

  assign word_match = (pll_word_i == ({1'b1, 13'd0, p_code_i, 3'd0, n_code_i,
                                       2'd0, k_code_i, 2'd0, m_code_i}));

  assign factor_match =
    ((({3'd0, n_code_i} + 8'd1) * ({6'd0, k_code_i} + 8'd1)) == multiplier_i)
    && ((17'(achieved_mhz_i) * 17'(divider_i)) == (17'(multiplier_i) * 17'd24));

  // A result with no factor set carries zeros everywhere.
  `PFS_ASSERT_IMP(a_miss_zero, clk_i, rst_ni, out_valid_i && !found_i, miss_zero, "nonzero miss")
  // The PLL word packs exactly the reported codes with the enable bit.
  `PFS_ASSERT_IMP(a_word_pack, clk_i, rst_ni, out_valid_i && found_i, word_match, "bad word")
  // Codes, multiplier, divider and frequency agree with each other.
  `PFS_ASSERT_IMP(a_factors, clk_i, rst_ni, out_valid_i && found_i, factor_match, "bad factors")
  // With no result waiting, a request is always taken.
  `PFS_ASSERT_IMP(a_ready_free, clk_i, rst_ni, !out_valid_i, in_ready_i, "ready dropped")
  // A stalled result stays put.
  `PFS_ASSERT_NXT(a_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(pll_word_i), "result changed under stall")

endmodule

bind pll_factor_solver pfs_checker u_pfs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_i     (in_ready_o),
  .out_valid_i    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .found_i        (found_o),
  .multiplier_i   (multiplier_o),
  .divider_i      (divider_o),
  .n_code_i       (n_code_o),
  .k_code_i       (k_code_o),
  .m_code_i       (m_code_o),
  .p_code_i       (p_code_o),
  .achieved_mhz_i (achieved_mhz_o),
  .pll_word_i     (pll_word_o)
);

// File: verif/pll_factor_solver_test.sv
// Self-checking testbench of the PLL factor solver: corner targets, back-pressure, random targets.
module pll_factor_solver_test;

  // Fixed reference and the limits of the total multiplier.
  localparam int unsigned REF_MHZ        = 24;
  localparam int unsigned MUL_DIRECT_MAX = 32;
  localparam int unsigned MUL_MAX        = 128;
  localparam logic [31:0] PLL_ENABLE     = 32'h8000_0000;

  // Post-divider codes as they appear in the result and in the PLL word.
  localparam logic [1:0] P_CODE_DIV1 = 2'd0;
  localparam logic [1:0] P_CODE_DIV2 = 2'd1;
  localparam logic [1:0] P_CODE_DIV4 = 2'd2;

  localparam int RANDOM_ITEMS   = 1300;
  localparam int BURST_ITEMS    = 30;
  localparam int LONG_HOLD      = 200;   // receiver hold-off while the pipeline fills
  localparam int SETTLE_CYCLES  = 20;    // well beyond the five-stage latency
  localparam int WATCHDOG_LIMIT = 2000;  // idle cycles; longest honest gap is the long hold
  localparam int MAX_PRINTED    = 100;   // mismatch lines printed, all are counted

  // One result as the block presents it.
  typedef struct packed {
    logic        found;
    logic [7:0]  multiplier;
    logic [4:0]  divider;
    logic [4:0]  n_code;
    logic [1:0]  k_code;
    logic [1:0]  m_code;
    logic [1:0]  p_code;
    logic [11:0] achieved_mhz;
    logic [31:0] pll_word;
  } pll_setting_t;

  // A request that was taken, with the setting it must produce.
  typedef struct packed {
    logic [11:0]  target;
    pll_setting_t setting;
  } pending_setting_t;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_ready_o;
  logic [11:0] target_mhz_i = '0;
  logic        out_valid_o;
  logic        out_ready_i  = 1'b0;
  logic        found_o;
  logic [7:0]  multiplier_o;
  logic [4:0]  divider_o;
  logic [4:0]  n_code_o;
  logic [1:0]  k_code_o;
  logic [1:0]  m_code_o;
  logic [1:0]  p_code_o;
  logic [11:0] achieved_mhz_o;
  logic [31:0] pll_word_o;

  pending_setting_t expected_settings[$];
  int mismatches = 0;
  int idle_cycles = 0;

  // Idle controls shared by the request side and the result side.
  bit send_idle = 1'b1;
  bit recv_idle = 1'b1;
  int hold_len  = 0;  // when nonzero, the receiver stalls this long before its next result

  pll_factor_solver u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .target_mhz_i   (target_mhz_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .found_o        (found_o),
    .multiplier_o   (multiplier_o),
    .divider_o      (divider_o),
    .n_code_o       (n_code_o),
    .k_code_o       (k_code_o),
    .m_code_o       (m_code_o),
    .p_code_o       (p_code_o),
    .achieved_mhz_o (achieved_mhz_o),
    .pll_word_o     (pll_word_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Candidate total dividers in the order the search tries them.
  function automatic int unsigned divider_at(input int idx);
    case (idx)
      0: return 1;
      1: return 2;
      2: return 3;
      3: return 4;
      4: return 6;
      5: return 8;
      6: return 12;
      default: return 16;
    endcase
  endfunction

  // Works out the PLL setting for one target. The first divider that gives an
  // exact, acceptable multiplier wins, even when that multiplier then cannot be
  // split into n and k; in that case nothing is found.
  function automatic pll_setting_t solve_target(input logic [11:0] target);
    pll_setting_t s;
    int unsigned  prod, q, mul, dv, n, k, m, p, idx;
    bit           hit;
    s   = '0;
    mul = 0;
    dv  = 0;
    n   = 0;
    k   = 0;
    m   = 0;
    p   = 0;
    hit = 1'b0;
    for (idx = 0; idx < 8; idx++) begin
      if (!hit) begin
        prod = target * divider_at(idx);
        q    = prod / REF_MHZ;
        if ((prod % REF_MHZ == 0) &&
            ((q <= MUL_DIRECT_MAX) || ((q <= MUL_MAX) && (q % 2 == 0 || q % 3 == 0)))) begin
          mul = q;
          dv  = divider_at(idx);
          hit = 1'b1;
        end
      end
    end
    // A zero multiplier is no PLL setting at all.
    if (!hit || mul == 0) return s;

    // Smallest post-multiplier k that leaves n within range.
    hit = 1'b0;
    for (int kk = 1; kk <= 4; kk++) begin
      if (!hit && (mul % kk == 0) && (mul / kk <= MUL_DIRECT_MAX)) begin
        k   = kk;
        n   = mul / kk;
        hit = 1'b1;
      end
    end
    if (!hit) return s;

    // Smallest pre-divider m whose quotient is a legal post-divider.
    hit = 1'b0;
    for (int mm = 1; mm <= 4; mm++) begin
      if (!hit && (dv % mm == 0) &&
          (dv / mm == 1 || dv / mm == 2 || dv / mm == 4)) begin
        m   = mm;
        p   = dv / mm;
        hit = 1'b1;
      end
    end
    if (!hit) return s;

    s.found        = 1'b1;
    s.multiplier   = 8'(mul);
    s.divider      = 5'(dv);
    s.n_code       = 5'(n - 1);
    s.k_code       = 2'(k - 1);
    s.m_code       = 2'(m - 1);
    s.p_code       = (p == 4) ? P_CODE_DIV4 : (p == 2) ? P_CODE_DIV2 : P_CODE_DIV1;
    s.achieved_mhz = 12'((REF_MHZ * n * k) / (m * p));
    s.pll_word     = PLL_ENABLE | {14'd0, s.p_code, 16'd0} | {19'd0, s.n_code, 8'd0} |
                     {26'd0, s.k_code, 4'd0} | {30'd0, s.m_code};
    return s;
  endfunction

  function automatic int draw_gap(input bit enabled);
    return enabled ? int'($urandom_range(0, 15)) : 0;
  endfunction

  // Random targets: a share built from legal n, k and divider so that found
  // results are common, the rest spread over the useful and the full range.
  function automatic logic [11:0] pick_target();
    int unsigned base, dv;
    case ($urandom_range(0, 9))
      0, 1, 2: return 12'($urandom_range(0, 4095));
      3, 4, 5: return 12'($urandom_range(0, 3100));
      default: begin
        base = REF_MHZ * $urandom_range(1, 32) * $urandom_range(1, 4);
        dv   = divider_at($urandom_range(0, 7));
        return (base % dv == 0) ? 12'(base / dv) : 12'(base);
      end
    endcase
  endfunction

  task automatic report_mismatch(input logic [11:0] target, input string what,
                                 input logic [31:0] got, input logic [31:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTED)
      $display("MISMATCH target %0d: %s got 0x%0h expected 0x%0h", target, what, got, want);
  endtask

  // Offers one request after a random gap and holds it until it is taken.
  task automatic send_target(input logic [11:0] target);
    int gap;
    gap = draw_gap(send_idle);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    target_mhz_i <= target;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    expected_settings.push_back('{target: target, setting: solve_target(target)});
  endtask

  // The sender stops until every outstanding result has been checked.
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (expected_settings.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // Field extremes, every divider in the search list, the zero target, a
  // multiplier too large for every divider, and first-divider multipliers
  // that are acceptable but have no split into n and k.
  task automatic test_corner_targets();
    logic [11:0] corners[$] = '{12'd0, 12'd4095, 12'd1, 12'd24, 12'd768, 12'd792,
                                12'd2352, 12'd3072, 12'd3096, 12'd12, 12'd8, 12'd6,
                                12'd4, 12'd3, 12'd2, 12'd105, 12'd36, 12'd2048,
                                12'd2376, 12'd1032, 12'd1020, 12'd2730, 12'd1365};
    send_idle = 1'b1;
    recv_idle = 1'b1;
    foreach (corners[i]) send_target(corners[i]);
  endtask

  // The receiver holds off for a long stretch while requests keep coming back
  // to back, so the pipeline fills and the input side must stall.
  task automatic test_output_backpressure();
    send_idle = 1'b0;
    recv_idle = 1'b0;
    hold_len  = LONG_HOLD;
    repeat (BURST_ITEMS) send_target(pick_target());
  endtask

  // Random targets in stretches that switch idling on and off on each side.
  task automatic test_random_targets();
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      send_idle = ((i / 150) % 2) == 0;
      recv_idle = ((i / 300) % 2) == 0;
      send_target(pick_target());
    end
  endtask

  // Result side: a random stall before each result, plus the long hold-off
  // when the back-pressure test asks for it.
  initial begin : result_receiver
    int stall;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_len > 0) begin
        out_ready_i <= 1'b0;
        repeat (hold_len) @(posedge clk_i);
        hold_len = 0;
      end
      stall = draw_gap(recv_idle);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
    end
  end

  // Every accepted result is checked field by field against the oldest request.
  always @(posedge clk_i) begin : result_checker
    pending_setting_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      if (expected_settings.size() == 0) begin
        report_mismatch(12'd0, "result with no request outstanding", pll_word_o, 32'd0);
      end else begin
        want = expected_settings.pop_front();
        if (found_o !== want.setting.found)
          report_mismatch(want.target, "found", 32'(found_o), 32'(want.setting.found));
        if (multiplier_o !== want.setting.multiplier)
          report_mismatch(want.target, "multiplier", 32'(multiplier_o),
                          32'(want.setting.multiplier));
        if (divider_o !== want.setting.divider)
          report_mismatch(want.target, "divider", 32'(divider_o), 32'(want.setting.divider));
        if (n_code_o !== want.setting.n_code)
          report_mismatch(want.target, "n_code", 32'(n_code_o), 32'(want.setting.n_code));
        if (k_code_o !== want.setting.k_code)
          report_mismatch(want.target, "k_code", 32'(k_code_o), 32'(want.setting.k_code));
        if (m_code_o !== want.setting.m_code)
          report_mismatch(want.target, "m_code", 32'(m_code_o), 32'(want.setting.m_code));
        if (p_code_o !== want.setting.p_code)
          report_mismatch(want.target, "p_code", 32'(p_code_o), 32'(want.setting.p_code));
        if (achieved_mhz_o !== want.setting.achieved_mhz)
          report_mismatch(want.target, "achieved_mhz", 32'(achieved_mhz_o),
                          32'(want.setting.achieved_mhz));
        if (pll_word_o !== want.setting.pll_word)
          report_mismatch(want.target, "pll_word", pll_word_o, want.setting.pll_word);
      end
    end
  end

  // Ends the run when neither channel has moved for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o === 1'b1) ||
        (out_valid_o === 1'b1 && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TIMEOUT: no request or result moved for %0d cycles", WATCHDOG_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_corner_targets();
    wait_for_results();
    test_output_backpressure();
    wait_for_results();
    test_random_targets();
    wait_for_results();

    // Let any stray result show up before the verdict.
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (expected_settings.size() != 0)
      report_mismatch(12'd0, "results still outstanding", expected_settings.size(), 32'd0);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hdl
hdl/pfs_pkg.sv
hdl/pll_factor_solver.sv
hdl/pfs_checker.sv
verif/pll_factor_solver_test.sv
